@@ sv/hfpr_pkg.sv @@
// ============================================================================
// hfpr_pkg: shared types and constants for the header framed pair receiver
// Reset values of the config registers, register indexes, frame phase codes
// and the reciprocal used for the divide-by-100 in the decode path.
// ============================================================================
package hfpr_pkg;

    // Default payload store depth (legal range 8..16)
    localparam int STORE_DEPTH_DEF = 10;

    // Config register reset values
    localparam logic [7:0] HEADER_FIRST_RST  = 8'h2C;
    localparam logic [7:0] HEADER_SECOND_RST = 8'h12;
    localparam logic [7:0] END_MARKER_RST    = 8'h5B;
    localparam logic [3:0] PAYLOAD_LIMIT_RST = 4'd10;

    // Config register indexes
    localparam int CFG_IDX_W = 2;
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_HEADER_FIRST  = 2'd0,
        REG_HEADER_SECOND = 2'd1,
        REG_END_MARKER    = 2'd2,
        REG_PAYLOAD_LIMIT = 2'd3
    } t_cfg_reg;

    // Frame phase, one-hot
    typedef enum logic [3:0] {
        PH_IDLE    = 4'b0001,
        PH_HEADER  = 4'b0010,
        PH_COLLECT = 4'b0100,
        PH_DONE    = 4'b1000
    } t_phase;

    // n / 100 == (n * DIV100_RECIP) >> DIV100_SHIFT for any 32-bit unsigned n
    localparam logic [31:0] DIV100_RECIP = 32'd1374389535;
    localparam int          DIV100_SHIFT = 37;
    localparam logic [31:0] HUNDRED      = 32'd100;

    // Widths of the decoded fields
    localparam int WORD_W  = 32;
    localparam int WHOLE_W = 26;
    localparam int FRAC_W  = 8;

endpackage

@@ sv/header_framed_pair_receiver_core.sv @@
// ============================================================================
// header_framed_pair_receiver_core: serial frame parser with two-value decode
// Waits for a two-byte header, collects payload bytes, then decodes two
// little-endian signed 32-bit hundredths values into whole and hundredths.
// ============================================================================
// One received byte is taken per rx beat, one every cycle while rx_ready is
// high. A frame opens with header_first then header_second; payload bytes
// are then stored until payload_limit bytes are in (0 acts as 1, above
// STORE_DEPTH acts as STORE_DEPTH) or a byte equal to end_marker arrives.
// That byte completes the frame: bytes 0..3 and 4..7 of the store are read as
// little-endian signed values in units of 0.01 and one result beat follows,
// carrying each value split into a whole part (truncated toward zero) and a
// signed hundredths remainder, plus a flag telling whether the marker ended
// the frame. The byte after a frame is swallowed and returns the parser to
// idle; the store is zeroed then unless the last stored byte was the marker,
// in which case a short next frame reuses the old upper bytes. Any byte that
// breaks the header also zeroes the store. The edge that accepts the
// completing rx beat latches the assembled words into stage 1; stage 2 then
// latches the reciprocal multiply that replaces the divide by 100, and the
// output register the remainder and sign fix-up, where the result beat
// appears. The three stages form an elastic pipeline, so rx_ready only
// drops when a result is stalled and all stages behind it are full. Config
// writes are always ready and should only be issued while no frame result
// is in flight.
// ============================================================================
module header_framed_pair_receiver_core #(
    parameter int STORE_DEPTH = hfpr_pkg::STORE_DEPTH_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    // Config write channel
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [hfpr_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [7:0]                      i_cfg_data,

    // Received bytes
    input  logic                            i_rx_valid,
    output logic                            o_rx_ready,
    input  logic [7:0]                      i_rx_byte,

    // Decoded results
    output logic                            o_res_valid,
    input  logic                            i_res_ready,
    output logic signed [hfpr_pkg::WHOLE_W-1:0] o_angle_whole,
    output logic signed [hfpr_pkg::FRAC_W-1:0]  o_angle_hundredths,
    output logic signed [hfpr_pkg::WHOLE_W-1:0] o_offset_whole,
    output logic signed [hfpr_pkg::FRAC_W-1:0]  o_offset_hundredths,
    output logic                            o_ended_by_marker
);

    localparam int CNT_W = $clog2(STORE_DEPTH + 1);  // holds 0..STORE_DEPTH
    localparam int IDX_W = $clog2(STORE_DEPTH);
    localparam int WW    = hfpr_pkg::WORD_W;
    localparam int QW    = hfpr_pkg::WHOLE_W;
    localparam int FW    = hfpr_pkg::FRAC_W;

    // ------------------------------------------------------------------
    // Config registers
    // ------------------------------------------------------------------
    logic [7:0] r_header_first;
    logic [7:0] r_header_second;
    logic [7:0] r_end_marker;
    logic [3:0] r_payload_limit;
    logic       cfg_we;

    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid & o_cfg_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_header_first  <= hfpr_pkg::HEADER_FIRST_RST;
            r_header_second <= hfpr_pkg::HEADER_SECOND_RST;
            r_end_marker    <= hfpr_pkg::END_MARKER_RST;
            r_payload_limit <= hfpr_pkg::PAYLOAD_LIMIT_RST;
        end else if (cfg_we) begin
            unique case (hfpr_pkg::t_cfg_reg'(i_cfg_index))
                hfpr_pkg::REG_HEADER_FIRST:  r_header_first  <= i_cfg_data;
                hfpr_pkg::REG_HEADER_SECOND: r_header_second <= i_cfg_data;
                hfpr_pkg::REG_END_MARKER:    r_end_marker    <= i_cfg_data;
                hfpr_pkg::REG_PAYLOAD_LIMIT: r_payload_limit <= i_cfg_data[3:0];
                default: ;
            endcase
        end
    end

    // ------------------------------------------------------------------
    // Pipeline handshake: s1 = assembled words, s2 = products, out = result
    // ------------------------------------------------------------------
    logic r_s1_valid, r_s2_valid, r_res_valid;
    logic s1_ready, s2_ready, s3_ready;
    logic rx_acc;

    assign s3_ready   = !r_res_valid || i_res_ready;
    assign s2_ready   = !r_s2_valid  || s3_ready;
    assign s1_ready   = !r_s1_valid  || s2_ready;
    assign o_rx_ready = s1_ready;
    assign rx_acc     = i_rx_valid & o_rx_ready;

    // ------------------------------------------------------------------
    // Frame parser
    // ------------------------------------------------------------------
    hfpr_pkg::t_phase r_phase, n_phase;
    logic [CNT_W-1:0] r_count, n_count;
    logic [7:0]       r_store [STORE_DEPTH];
    logic [7:0]       n_store [STORE_DEPTH];
    logic [7:0]       r_last_byte, n_last_byte;

    logic [CNT_W-1:0] lim_raw, lim_eff, cnt_inc;
    logic             is_marker, frame_done, launch;

    assign lim_raw   = CNT_W'(r_payload_limit);
    assign lim_eff   = (lim_raw == '0) ? CNT_W'(1)
                     : (lim_raw > CNT_W'(STORE_DEPTH)) ? CNT_W'(STORE_DEPTH) : lim_raw;
    assign cnt_inc   = r_count + CNT_W'(1);
    assign is_marker = (i_rx_byte == r_end_marker);
    assign frame_done = (cnt_inc >= lim_eff) || is_marker;

    always_comb begin
        n_phase     = r_phase;
        n_count     = r_count;
        n_store     = r_store;
        n_last_byte = r_last_byte;
        launch      = 1'b0;
        if (rx_acc) begin
            unique case (r_phase)
                hfpr_pkg::PH_IDLE: begin
                    if (i_rx_byte == r_header_first) begin
                        n_phase = hfpr_pkg::PH_HEADER;
                    end else begin
                        n_count = '0;
                        for (int k = 0; k < STORE_DEPTH; k++) n_store[k] = '0;
                    end
                end
                hfpr_pkg::PH_HEADER: begin
                    if (i_rx_byte == r_header_second) begin
                        n_phase = hfpr_pkg::PH_COLLECT;
                    end else begin
                        n_phase = hfpr_pkg::PH_IDLE;
                        n_count = '0;
                        for (int k = 0; k < STORE_DEPTH; k++) n_store[k] = '0;
                    end
                end
                hfpr_pkg::PH_COLLECT: begin
                    // count stays below STORE_DEPTH here, so the slot always exists
                    n_store[r_count[IDX_W-1:0]] = i_rx_byte;
                    n_count     = cnt_inc;
                    n_last_byte = i_rx_byte;
                    if (frame_done) begin
                        n_phase = hfpr_pkg::PH_DONE;
                        launch  = 1'b1;
                    end
                end
                hfpr_pkg::PH_DONE: begin
                    n_phase = hfpr_pkg::PH_IDLE;
                    n_count = '0;
                    if (r_last_byte != r_end_marker) begin
                        for (int k = 0; k < STORE_DEPTH; k++) n_store[k] = '0;
                    end
                end
                default: begin
                    n_phase = hfpr_pkg::PH_IDLE;
                    n_count = '0;
                    for (int k = 0; k < STORE_DEPTH; k++) n_store[k] = '0;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= hfpr_pkg::PH_IDLE;
            r_count     <= '0;
            r_last_byte <= '0;
            for (int k = 0; k < STORE_DEPTH; k++) r_store[k] <= '0;
        end else begin
            r_phase     <= n_phase;
            r_count     <= n_count;
            r_last_byte <= n_last_byte;
            r_store     <= n_store;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: latch the two words (little-endian, current byte merged)
    // ------------------------------------------------------------------
    logic [WW-1:0] r_s1_angle, r_s1_offset;
    logic          r_s1_marker;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (s1_ready) begin
            r_s1_valid <= launch;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && launch) begin
            r_s1_angle  <= {n_store[3], n_store[2], n_store[1], n_store[0]};
            r_s1_offset <= {n_store[7], n_store[6], n_store[5], n_store[4]};
            r_s1_marker <= is_marker;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: magnitude and reciprocal multiply (quotient by 100)
    // ------------------------------------------------------------------
    logic [WW-1:0]   a_mag, o_mag;
    logic [2*WW-1:0] a_prod, o_prod;
    logic [WW-1:0]   r_s2_a_mag, r_s2_o_mag;
    logic [QW-1:0]   r_s2_a_q, r_s2_o_q;
    logic            r_s2_a_neg, r_s2_o_neg, r_s2_marker;

    assign a_mag  = r_s1_angle[WW-1]  ? (WW'(0) - r_s1_angle)  : r_s1_angle;
    assign o_mag  = r_s1_offset[WW-1] ? (WW'(0) - r_s1_offset) : r_s1_offset;
    assign a_prod = {{WW{1'b0}}, a_mag} * {{WW{1'b0}}, hfpr_pkg::DIV100_RECIP};
    assign o_prod = {{WW{1'b0}}, o_mag} * {{WW{1'b0}}, hfpr_pkg::DIV100_RECIP};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s2_valid <= 1'b0;
        end else if (s2_ready) begin
            r_s2_valid <= r_s1_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && r_s1_valid) begin
            r_s2_a_mag  <= a_mag;
            r_s2_o_mag  <= o_mag;
            r_s2_a_q    <= a_prod[hfpr_pkg::DIV100_SHIFT +: QW];
            r_s2_o_q    <= o_prod[hfpr_pkg::DIV100_SHIFT +: QW];
            r_s2_a_neg  <= r_s1_angle[WW-1];
            r_s2_o_neg  <= r_s1_offset[WW-1];
            r_s2_marker <= r_s1_marker;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: remainder, sign restore, output register
    // ------------------------------------------------------------------
    logic [WW-1:0] a_rem, o_rem;
    logic [FW-1:0] a_frac, o_frac;
    logic [QW-1:0] a_whole, o_whole;

    assign a_rem   = r_s2_a_mag - (WW'(r_s2_a_q) * hfpr_pkg::HUNDRED);
    assign o_rem   = r_s2_o_mag - (WW'(r_s2_o_q) * hfpr_pkg::HUNDRED);
    assign a_frac  = r_s2_a_neg ? (FW'(0) - a_rem[FW-1:0]) : a_rem[FW-1:0];
    assign o_frac  = r_s2_o_neg ? (FW'(0) - o_rem[FW-1:0]) : o_rem[FW-1:0];
    assign a_whole = r_s2_a_neg ? (QW'(0) - r_s2_a_q) : r_s2_a_q;
    assign o_whole = r_s2_o_neg ? (QW'(0) - r_s2_o_q) : r_s2_o_q;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_res_valid <= 1'b0;
        end else if (s3_ready) begin
            r_res_valid <= r_s2_valid;
        end
    end

    logic signed [QW-1:0] r_angle_whole, r_offset_whole;
    logic signed [FW-1:0] r_angle_frac, r_offset_frac;
    logic                 r_marker;

    always_ff @(posedge i_clk) begin
        if (s3_ready && r_s2_valid) begin
            r_angle_whole  <= a_whole;
            r_angle_frac   <= a_frac;
            r_offset_whole <= o_whole;
            r_offset_frac  <= o_frac;
            r_marker       <= r_s2_marker;
        end
    end

    assign o_res_valid         = r_res_valid;
    assign o_angle_whole       = r_angle_whole;
    assign o_angle_hundredths  = r_angle_frac;
    assign o_offset_whole      = r_offset_whole;
    assign o_offset_hundredths = r_offset_frac;
    assign o_ended_by_marker   = r_marker;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    // a decode job waiting in stage 1 means the frame is still marked done
    a_s1_in_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_s1_valid |-> (r_phase == hfpr_pkg::PH_DONE))
        else $error("stage 1 holds a job outside the done phase");

    // a completing payload beat always launches a decode
    a_launch: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (rx_acc && r_phase == hfpr_pkg::PH_COLLECT && frame_done) |=> r_s1_valid)
        else $error("completed frame did not launch a decode");

    // while collecting, the store always has room for the next byte
    a_cnt_collect: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == hfpr_pkg::PH_COLLECT) |-> (r_count < CNT_W'(STORE_DEPTH)))
        else $error("payload count reached store depth while collecting");

    // count is zero before collection starts
    a_cnt_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == hfpr_pkg::PH_IDLE || r_phase == hfpr_pkg::PH_HEADER)
            |-> (r_count == '0))
        else $error("payload count nonzero outside a frame");

    // a finished frame holds at least one stored byte
    a_cnt_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == hfpr_pkg::PH_DONE)
            |-> (r_count != '0 && r_count <= CNT_W'(STORE_DEPTH)))
        else $error("done phase with bad payload count");

endmodule

@@ tb/sv/tb_top.sv @@
// ============================================================================
// tb_top: self-checking bench for header_framed_pair_receiver_core
// Feeds received bytes through the rx channel. A directed table comes first,
// then randomized frames under a series of config settings. A byte-level
// parser model predicts the result beats the directed table does not give
// by hand; each beat from the block is compared with its expected pair field by field.
// ============================================================================
module tb_top;

    localparam int DEPTH       = hfpr_pkg::STORE_DEPTH_DEF;
    localparam int WHOLE_W     = hfpr_pkg::WHOLE_W;
    localparam int FRAC_W      = hfpr_pkg::FRAC_W;
    localparam int STALL_LIMIT = 2000;  // cycles with no beat on any channel
    localparam int DRAIN_WAIT  = 8;     // result pipe is 3 deep, allow margin
    localparam int N_PHASES    = 12;
    localparam int PHASE_BYTES = 140;

    // One decoded result beat
    typedef struct packed {
        logic signed [WHOLE_W-1:0] angle_whole;
        logic signed [FRAC_W-1:0]  angle_hundredths;
        logic signed [WHOLE_W-1:0] offset_whole;
        logic signed [FRAC_W-1:0]  offset_hundredths;
        logic                      ended_by_marker;
    } t_decoded_pair;

    // Directed row: rx byte, plus a hand-written result where one is obvious
    typedef struct packed {
        logic [7:0]    rx;
        logic          typed;
        t_decoded_pair want;
    } t_stim_row;

    localparam t_decoded_pair NO_PAIR = '0;

    // Reset config: header 2C 12, marker 5B, limit 10.
    localparam int N_DIRECTED = 27;
    localparam t_stim_row DIRECTED_ROWS [N_DIRECTED] = '{
        '{8'h00, 1'b0, NO_PAIR},    // junk while idle, store cleared
        '{8'h2C, 1'b0, NO_PAIR},
        '{8'h12, 1'b0, NO_PAIR},
        '{8'hFF, 1'b0, NO_PAIR},    // angle = -1
        '{8'hFF, 1'b0, NO_PAIR},
        '{8'hFF, 1'b0, NO_PAIR},
        '{8'hFF, 1'b0, NO_PAIR},
        '{8'h00, 1'b0, NO_PAIR},    // offset = most negative 32-bit value
        '{8'h00, 1'b0, NO_PAIR},
        '{8'h00, 1'b0, NO_PAIR},
        '{8'h80, 1'b0, NO_PAIR},
        '{8'h00, 1'b0, NO_PAIR},
        // tenth payload byte hits the limit, no marker
        '{8'hFF, 1'b1, '{26'sd0, -8'sd1, -26'sd21474836, -8'sd48, 1'b0}},
        '{8'h2C, 1'b0, NO_PAIR},    // trailing byte swallowed, store cleared
        '{8'h2C, 1'b0, NO_PAIR},
        '{8'h2C, 1'b0, NO_PAIR},    // repeated first header byte breaks header
        '{8'h2C, 1'b0, NO_PAIR},
        '{8'h12, 1'b0, NO_PAIR},
        // marker as the only payload byte: angle = 0x5B, rest zero
        '{8'h5B, 1'b1, '{26'sd0, 8'sd91, 26'sd0, 8'sd0, 1'b1}},
        '{8'h00, 1'b0, NO_PAIR},    // ended on marker: store kept
        '{8'h2C, 1'b0, NO_PAIR},
        '{8'h12, 1'b0, NO_PAIR},
        '{8'hFF, 1'b0, NO_PAIR},    // angle = most positive 32-bit value
        '{8'hFF, 1'b0, NO_PAIR},
        '{8'hFF, 1'b0, NO_PAIR},
        '{8'h7F, 1'b0, NO_PAIR},
        // short frame: offset picks up old store bytes 5..7 (zero)
        '{8'h5B, 1'b1, '{26'sd21474836, 8'sd47, 26'sd0, 8'sd91, 1'b1}}
    };

    // Low nibble of the limit written in each random phase (0 and >10 too)
    localparam logic [3:0] LIMIT_PLAN [N_PHASES] =
        '{4'd15, 4'd0, 4'd1, 4'd2, 4'd3, 4'd5, 4'd8, 4'd9, 4'd10, 4'd11, 4'd4, 4'd7};

    // ------------------------------------------------------------------------
    // DUT signals; the bench-driven ones are known from time zero
    // ------------------------------------------------------------------------
    logic                               i_clk = 1'b0;
    logic                               i_rst_n = 1'b0;
    logic                               i_cfg_valid = 1'b0;
    logic                               o_cfg_ready;
    logic [hfpr_pkg::CFG_IDX_W-1:0]     i_cfg_index = '0;
    logic [7:0]                         i_cfg_data = '0;
    logic                               i_rx_valid = 1'b0;
    logic                               o_rx_ready;
    logic [7:0]                         i_rx_byte = '0;
    logic                               o_res_valid;
    logic                               i_res_ready = 1'b0;
    logic signed [WHOLE_W-1:0]          o_angle_whole;
    logic signed [FRAC_W-1:0]           o_angle_hundredths;
    logic signed [WHOLE_W-1:0]          o_offset_whole;
    logic signed [FRAC_W-1:0]           o_offset_hundredths;
    logic                               o_ended_by_marker;

    header_framed_pair_receiver_core uut (
        .i_clk               (i_clk),
        .i_rst_n             (i_rst_n),
        .i_cfg_valid         (i_cfg_valid),
        .o_cfg_ready         (o_cfg_ready),
        .i_cfg_index         (i_cfg_index),
        .i_cfg_data          (i_cfg_data),
        .i_rx_valid          (i_rx_valid),
        .o_rx_ready          (o_rx_ready),
        .i_rx_byte           (i_rx_byte),
        .o_res_valid         (o_res_valid),
        .i_res_ready         (i_res_ready),
        .o_angle_whole       (o_angle_whole),
        .o_angle_hundredths  (o_angle_hundredths),
        .o_offset_whole      (o_offset_whole),
        .o_offset_hundredths (o_offset_hundredths),
        .o_ended_by_marker   (o_ended_by_marker)
    );

    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // ------------------------------------------------------------------------
    // Parser mirror: config copy and frame state
    // ------------------------------------------------------------------------
    logic [7:0] hdr_first  = hfpr_pkg::HEADER_FIRST_RST;
    logic [7:0] hdr_second = hfpr_pkg::HEADER_SECOND_RST;
    logic [7:0] end_mark   = hfpr_pkg::END_MARKER_RST;
    logic [3:0] pay_limit  = hfpr_pkg::PAYLOAD_LIMIT_RST;

    hfpr_pkg::t_phase mirror_phase = hfpr_pkg::PH_IDLE;
    int               mirror_count = 0;
    logic [7:0]       mirror_store [DEPTH];

    t_decoded_pair pending_pairs [$];   // results still owed by the block
    int            mismatches = 0;
    int            bytes_sent = 0;
    bit            steady = 1'b0;       // no idling on either side while set

    task automatic note_mismatch(input string msg);
        mismatches++;
        $display("MISMATCH @%0t: %s", $time, msg);
    endtask

    function automatic void clear_frame();
        mirror_phase = hfpr_pkg::PH_IDLE;
        mirror_count = 0;
        foreach (mirror_store[k]) mirror_store[k] = 8'h00;
    endfunction

    function automatic void apply_reg(input hfpr_pkg::t_cfg_reg idx, input logic [7:0] d);
        case (idx)
            hfpr_pkg::REG_HEADER_FIRST:  hdr_first  = d;
            hfpr_pkg::REG_HEADER_SECOND: hdr_second = d;
            hfpr_pkg::REG_END_MARKER:    end_mark   = d;
            hfpr_pkg::REG_PAYLOAD_LIMIT: pay_limit  = d[3:0];
            default: ;
        endcase
    endfunction

    // Effective limit: 0 acts as 1, anything above the store depth clamps
    function automatic int eff_limit();
        if (pay_limit == 4'd0) return 1;
        if (int'(pay_limit) > DEPTH) return DEPTH;
        return int'(pay_limit);
    endfunction

    // Advance the parser by one byte; returns 1 when a frame completes
    function automatic bit parse_byte(input logic [7:0] b, output t_decoded_pair pair);
        logic signed [31:0] angle_raw;
        logic signed [31:0] offset_raw;
        bit                 done;
        pair = '0;
        done = 1'b0;
        if (mirror_phase == hfpr_pkg::PH_IDLE && b == hdr_first) begin
            mirror_phase = hfpr_pkg::PH_HEADER;
        end else if (mirror_phase == hfpr_pkg::PH_HEADER && b == hdr_second) begin
            mirror_phase = hfpr_pkg::PH_COLLECT;
        end else if (mirror_phase == hfpr_pkg::PH_COLLECT) begin
            if (mirror_count < DEPTH) begin
                mirror_store[mirror_count] = b;
                mirror_count++;
            end
            if (mirror_count >= eff_limit() || b == end_mark) begin
                // little-endian words; / and % on signed ints truncate toward 0
                angle_raw  = {mirror_store[3], mirror_store[2],
                              mirror_store[1], mirror_store[0]};
                offset_raw = {mirror_store[7], mirror_store[6],
                              mirror_store[5], mirror_store[4]};
                pair.angle_whole       = WHOLE_W'(angle_raw / 100);
                pair.angle_hundredths  = FRAC_W'(angle_raw % 100);
                pair.offset_whole      = WHOLE_W'(offset_raw / 100);
                pair.offset_hundredths = FRAC_W'(offset_raw % 100);
                pair.ended_by_marker   = (b == end_mark);
                mirror_phase = hfpr_pkg::PH_DONE;
                done = 1'b1;
            end
        end else if (mirror_phase == hfpr_pkg::PH_DONE) begin
            // byte after a frame is eaten; store survives only a marker ending
            if (mirror_count >= 1 && mirror_store[mirror_count-1] == end_mark) begin
                mirror_phase = hfpr_pkg::PH_IDLE;
                mirror_count = 0;
            end else begin
                clear_frame();
            end
        end else begin
            clear_frame();
        end
        return done;
    endfunction

    // ------------------------------------------------------------------------
    // rx sender: random gaps before a beat, valid held until accepted.
    // Leaves valid high after the accepting edge; the next call or the
    // caller lowers it, so valid never gets two updates in one step.
    // ------------------------------------------------------------------------
    task automatic send_byte(input logic [7:0] b, input bit typed = 1'b0,
                             input t_decoded_pair typed_pair = '0);
        t_decoded_pair pred;
        bit            done;
        while (!steady && $urandom_range(0, 99) < 13) begin
            i_rx_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_rx_valid <= 1'b1;
        i_rx_byte  <= b;
        @(posedge i_clk);
        while (!o_rx_ready) @(posedge i_clk);
        bytes_sent++;
        done = parse_byte(b, pred);
        if (typed)
            pending_pairs.push_back(typed_pair);
        else if (done)
            pending_pairs.push_back(pred);
    endtask

    task automatic write_reg(input hfpr_pkg::t_cfg_reg idx, input logic [7:0] d);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= d;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        apply_reg(idx, d);
    endtask

    // Stop sending and let every owed result drain, then let the pipe settle
    task automatic drain_results();
        i_rx_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_pairs.size() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    // Payload byte biased toward sign/extreme values, never the end marker
    function automatic logic [7:0] payload_byte();
        logic [7:0] v;
        case ($urandom_range(0, 5))
            0: v = 8'h00;
            1: v = 8'hFF;
            2: v = 8'h7F;
            3: v = 8'h80;
            default: v = 8'($urandom_range(0, 255));
        endcase
        if (v == end_mark) v = v ^ 8'h01;
        return v;
    endfunction

    // Well-formed frame: header, 1..limit payload bytes, trailing byte.
    // Shorter than the limit means it must end on the marker; at the limit
    // the last byte is the marker about a third of the time.
    task automatic send_frame();
        int         lim;
        int         len;
        logic [7:0] last;
        lim = eff_limit();
        len = $urandom_range(1, lim);
        send_byte(hdr_first);
        send_byte(hdr_second);
        for (int k = 0; k < len - 1; k++) send_byte(payload_byte());
        if (len < lim || $urandom_range(0, 99) < 30)
            last = end_mark;
        else
            last = payload_byte();
        send_byte(last);
        // trailing byte: often the first header byte, which must not open a frame
        send_byte($urandom_range(0, 1) ? hdr_first : 8'($urandom_range(0, 255)));
    endtask

    task automatic send_broken_header();
        logic [7:0] wrong;
        wrong = $urandom_range(0, 1) ? hdr_first : 8'($urandom_range(0, 255));
        if (wrong == hdr_second) wrong = wrong ^ 8'h80;
        send_byte(hdr_first);
        send_byte(wrong);
    endtask

    // ------------------------------------------------------------------------
    // Result side: random back-pressure, compare each beat with the oldest
    // owed result
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_res_ready <= steady || ($urandom_range(0, 99) >= 13);
    end

    always @(posedge i_clk) begin : result_check
        t_decoded_pair want;
        if (i_rst_n && o_res_valid && i_res_ready) begin
            if (pending_pairs.size() == 0) begin
                note_mismatch("result beat with no frame completed");
            end else begin
                want = pending_pairs.pop_front();
                if (o_angle_whole !== want.angle_whole)
                    note_mismatch($sformatf("angle_whole got %0d want %0d",
                                            o_angle_whole, want.angle_whole));
                if (o_angle_hundredths !== want.angle_hundredths)
                    note_mismatch($sformatf("angle_hundredths got %0d want %0d",
                                            o_angle_hundredths, want.angle_hundredths));
                if (o_offset_whole !== want.offset_whole)
                    note_mismatch($sformatf("offset_whole got %0d want %0d",
                                            o_offset_whole, want.offset_whole));
                if (o_offset_hundredths !== want.offset_hundredths)
                    note_mismatch($sformatf("offset_hundredths got %0d want %0d",
                                            o_offset_hundredths, want.offset_hundredths));
                if (o_ended_by_marker !== want.ended_by_marker)
                    note_mismatch($sformatf("ended_by_marker got %b want %b",
                                            o_ended_by_marker, want.ended_by_marker));
            end
        end
    end

    // Watchdog: any beat on any channel restarts the count
    initial begin : watchdog
        int stuck;
        stuck = 0;
        while (stuck < STALL_LIMIT) begin
            @(posedge i_clk);
            if ((i_rx_valid && o_rx_ready) || (o_res_valid && i_res_ready) ||
                (i_cfg_valid && o_cfg_ready))
                stuck = 0;
            else
                stuck++;
        end
        $display("Verification failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------------
    initial begin : main_seq
        int         roll;
        int         target;
        logic [7:0] hf;
        logic [7:0] hs;
        logic [7:0] em;
        logic [7:0] lim_data;

        clear_frame();
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed table against reset config
        for (int r = 0; r < N_DIRECTED; r++)
            send_byte(DIRECTED_ROWS[r].rx, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);

        // Random phases; each starts with a full drain and a fresh config
        for (int p = 0; p < N_PHASES; p++) begin
            drain_results();
            case (p)
                0: begin hf = 8'h00; hs = 8'hFF; em = 8'hFF; lim_data = 8'hFF; end
                1: begin hf = 8'hFF; hs = 8'h00; em = 8'h00; lim_data = 8'hF0; end
                default: begin
                    hf = 8'($urandom_range(0, 255));
                    hs = 8'($urandom_range(0, 255));
                    em = 8'($urandom_range(0, 255));
                    lim_data = {4'($urandom_range(0, 15)), LIMIT_PLAN[p]};
                end
            endcase
            write_reg(hfpr_pkg::REG_HEADER_FIRST, hf);
            write_reg(hfpr_pkg::REG_HEADER_SECOND, hs);
            write_reg(hfpr_pkg::REG_END_MARKER, em);
            write_reg(hfpr_pkg::REG_PAYLOAD_LIMIT, lim_data);
            i_cfg_valid <= 1'b0;

            steady = (p == 5);  // one phase runs with no idling at all
            target = bytes_sent + PHASE_BYTES;
            while (bytes_sent < target) begin
                roll = $urandom_range(0, 99);
                if (roll < 78)
                    send_frame();
                else if (roll < 88)
                    send_broken_header();
                else
                    send_byte(8'($urandom_range(0, 255)));
            end
            steady = 1'b0;
        end

        drain_results();
        while (pending_pairs.size() != 0) begin
            void'(pending_pairs.pop_front());
            note_mismatch("expected result never arrived");
        end

        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

@@ filelist.f @@
sv/hfpr_pkg.sv
sv/header_framed_pair_receiver_core.sv
tb/sv/tb_top.sv
